// File: rtl/assert_macros.svh
// assertion helpers used by the filter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/iirtdf2_pkg.sv
package iirtdf2_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_ORDER      = 4;
    localparam int DEF_COEF_FRAC_BITS = 20;
    localparam int DEF_SAMPLE_WIDTH   = 16;

    // fixed widths
    localparam int COEF_WIDTH     = 24;
    localparam int SUM_WIDTH      = 48;
    localparam int ORDER_WIDTH    = 3;
    localparam int CFG_DATA_WIDTH = 2 * COEF_WIDTH;
    localparam int MIN_ORDER      = 2;

    // register indexes
    localparam int CFG_FILTER_ORDER = 0;
    localparam int CFG_LEAD_COEF    = 1;
    localparam int CFG_PAIR_BASE    = 2;

    // microcode
    localparam int PC_WIDTH = 3;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_B0X,
        MUL_BK_X,
        MUL_AK_Y
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_FIRST,
        ACC_UPPER,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_LOOP,
        JMP_DONE
    } jump_t;

    typedef struct packed {
        mul_sel_t              mul;
        logic                  next_pair;
        acc_op_t               acc;
        logic                  wr_y;
        logic                  wr_s;
        jump_t                 jmp;
        logic [PC_WIDTH-1:0]   target;
    } uword_t;

    localparam logic [PC_WIDTH-1:0] STEP_B0X   = 3'd0;
    localparam logic [PC_WIDTH-1:0] STEP_FIRST = 3'd1;
    localparam logic [PC_WIDTH-1:0] STEP_ROUND = 3'd2;
    localparam logic [PC_WIDTH-1:0] STEP_UPPER = 3'd3;
    localparam logic [PC_WIDTH-1:0] STEP_SUB   = 3'd4;
    localparam logic [PC_WIDTH-1:0] STEP_STORE = 3'd5;
    localparam logic [PC_WIDTH-1:0] STEP_DONE  = 3'd6;

    // control program: one word per step
    function automatic uword_t ucode(input logic [PC_WIDTH-1:0] pc);
        uword_t w;
        w.mul       = MUL_NONE;
        w.next_pair = 1'b0;
        w.acc       = ACC_HOLD;
        w.wr_y      = 1'b0;
        w.wr_s      = 1'b0;
        w.jmp       = JMP_NEXT;
        w.target    = STEP_B0X;
        case (pc)
            STEP_B0X: begin
                w.mul = MUL_B0X;
            end
            STEP_FIRST: begin
                w.mul = MUL_BK_X;
                w.acc = ACC_FIRST;
            end
            STEP_ROUND: begin
                w.wr_y = 1'b1;
            end
            STEP_UPPER: begin
                w.mul = MUL_AK_Y;
                w.acc = ACC_UPPER;
            end
            STEP_SUB: begin
                w.mul       = MUL_BK_X;
                w.next_pair = 1'b1;
                w.acc       = ACC_SUB;
            end
            STEP_STORE: begin
                w.wr_s   = 1'b1;
                w.jmp    = JMP_LOOP;
                w.target = STEP_UPPER;
            end
            default: begin
                w.jmp = JMP_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/iir_transposed_df2_filter_top.sv
// IIR filter of order 2 to MAX_ORDER (register filter_order, clamped into range) in transposed
// direct form II with the leading reverse coefficient fixed at 1. Each request on the
// s_ side carries one signed sample x; each request on the m_ side carries
// y = round_half_up((s0 + b0*x) / 2^COEF_FRAC_BITS), saturated to SAMPLE_WIDTH bits, with
// m_tuser high when it was clipped. The clipped y is fed back: the delay sums update as
// s(k-1) = s(k) + bk*x - ak*y, each saturated to 48 bits, and sums above the order are
// zeroed, so raising the order starts the new sums from zero. Coefficients are Q3.20
// (24 bits); pair register k holds bk in bits 47..24 and ak in bits 23..0. Delay sums are
// cleared by reset. One 24 x SAMPLE_WIDTH multiplier is shared by all products and driven
// by a small microcode program: three setup steps, three steps per delay sum and one
// output step. A new sample is taken in the same cycle the previous result moves into
// the output register, and the output register lets the next sample run while the result
// waits for m_tready. Configuration writes are taken at any time and should only be issued
// while no sample is in flight.
`include "assert_macros.svh"

module iir_transposed_df2_filter_top #(
    parameter int MAX_ORDER      = iirtdf2_pkg::DEF_MAX_ORDER,
    parameter int COEF_FRAC_BITS = iirtdf2_pkg::DEF_COEF_FRAC_BITS,
    parameter int SAMPLE_WIDTH   = iirtdf2_pkg::DEF_SAMPLE_WIDTH,
    localparam int TDATA_WIDTH     = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int CFG_INDEX_WIDTH = $clog2(MAX_ORDER + iirtdf2_pkg::CFG_PAIR_BASE)
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input samples
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [TDATA_WIDTH-1:0]                s_tdata,   // sample
    // filtered samples
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [TDATA_WIDTH-1:0]                m_tdata,   // filtered_sample
    output logic                                  m_tuser,   // saturated
    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]            cfg_index,
    input  logic [iirtdf2_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    localparam int CW     = iirtdf2_pkg::COEF_WIDTH;
    localparam int SW     = iirtdf2_pkg::SUM_WIDTH;
    localparam int NW     = $clog2(MAX_ORDER + 1);   // holds an order
    localparam int PW     = $clog2(MAX_ORDER);       // indexes a pair
    localparam int PROD_W = CW + SAMPLE_WIDTH;
    localparam int ACC_W  = SW + 2;                  // three terms of at most 48 bits

    localparam logic [ACC_W-1:0] ACC_RND =
        {{(ACC_W - 1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] Y_MIN   = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SUM_MIN = ~SUM_MAX;
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX_S = Y_MAX[SAMPLE_WIDTH-1:0];
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN_S = Y_MIN[SAMPLE_WIDTH-1:0];
    localparam logic [CW-1:0] B0_RESET = CW'(64'sd1 <<< COEF_FRAC_BITS);

    // sequencer control
    logic                                 busy_reg, busy_next;
    logic [iirtdf2_pkg::PC_WIDTH-1:0]     pc_reg, pc_next;
    logic [NW-1:0]                        ptr_reg, ptr_next;
    iirtdf2_pkg::uword_t                  uw;

    // datapath
    logic signed [SAMPLE_WIDTH-1:0]       x_reg, x_next;
    logic signed [PROD_W-1:0]             prod_reg, prod_next;
    logic signed [ACC_W-1:0]              acc_reg, acc_next;
    logic signed [SAMPLE_WIDTH-1:0]       y_reg, y_next;
    logic                                 sat_reg, sat_next;
    logic signed [SW-1:0]                 sum_reg [MAX_ORDER];
    logic signed [SW-1:0]                 sum_next [MAX_ORDER];

    // output register
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic signed [SAMPLE_WIDTH-1:0]       m_data_reg, m_data_next;
    logic                                 m_tuser_reg, m_tuser_next;

    // configuration
    logic [iirtdf2_pkg::ORDER_WIDTH-1:0]  order_reg, order_next;
    logic signed [CW-1:0]                 b0_reg, b0_next;
    logic signed [CW-1:0]                 b_reg [MAX_ORDER];
    logic signed [CW-1:0]                 b_next [MAX_ORDER];
    logic signed [CW-1:0]                 a_reg [MAX_ORDER];
    logic signed [CW-1:0]                 a_next [MAX_ORDER];

    logic [NW-1:0]                        n_cur;
    logic [NW-1:0]                        ptr_inc;
    logic                                 more_pairs;
    logic [PW-1:0]                        mul_pair;
    logic signed [CW-1:0]                 coef_sel;
    logic signed [SAMPLE_WIDTH-1:0]       opnd_sel;
    logic signed [SW-1:0]                 upper_sum;
    logic signed [ACC_W-1:0]              y_wide;
    logic signed [ACC_W-1:0]              acc_sat;
    logic                                 out_free;
    logic                                 finishing;
    logic [PW-1:0]                        cfg_pair;

    // order clamped into the supported range
    always_comb begin
        if (int'(order_reg) < iirtdf2_pkg::MIN_ORDER) begin
            n_cur = NW'(iirtdf2_pkg::MIN_ORDER);
        end else if (int'(order_reg) > MAX_ORDER) begin
            n_cur = NW'(MAX_ORDER);
        end else begin
            n_cur = NW'(order_reg);
        end
    end

    assign uw         = iirtdf2_pkg::ucode(pc_reg);
    assign ptr_inc    = ptr_reg + NW'(1);
    assign more_pairs = ptr_inc < n_cur;
    assign cfg_pair   = PW'(int'(cfg_index) - iirtdf2_pkg::CFG_PAIR_BASE);
    assign cfg_ready  = 1'b1;

    // top delay sum of the order reads as zero
    assign upper_sum = more_pairs ? sum_reg[ptr_inc[PW-1:0]] : '0;

    // shared multiplier operands
    assign mul_pair = uw.next_pair ? ptr_inc[PW-1:0] : ptr_reg[PW-1:0];
    always_comb begin
        case (uw.mul)
            iirtdf2_pkg::MUL_B0X: begin
                coef_sel = b0_reg;
                opnd_sel = x_reg;
            end
            iirtdf2_pkg::MUL_BK_X: begin
                // look-ahead past the last pair gives a product nobody uses
                coef_sel = (uw.next_pair && !more_pairs) ? '0 : b_reg[mul_pair];
                opnd_sel = x_reg;
            end
            iirtdf2_pkg::MUL_AK_Y: begin
                coef_sel = a_reg[ptr_reg[PW-1:0]];
                opnd_sel = y_reg;
            end
            default: begin
                coef_sel = '0;
                opnd_sel = '0;
            end
        endcase
    end

    // rounded output before clipping, and delay sum clipping
    assign y_wide  = acc_reg >>> COEF_FRAC_BITS;
    assign acc_sat = (acc_reg > SUM_MAX) ? SUM_MAX : ((acc_reg < SUM_MIN) ? SUM_MIN : acc_reg);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign finishing = busy_reg && (uw.jmp == iirtdf2_pkg::JMP_DONE) && out_free;
    assign s_tready  = !busy_reg || finishing;

    always_comb begin
        busy_next     = busy_reg;
        pc_next       = pc_reg;
        ptr_next      = ptr_reg;
        x_next        = x_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        y_next        = y_reg;
        sat_next      = sat_reg;
        sum_next      = sum_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_tuser_next  = m_tuser_reg;
        order_next    = order_reg;
        b0_next       = b0_reg;
        b_next        = b_reg;
        a_next        = a_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (busy_reg) begin
            if (uw.mul != iirtdf2_pkg::MUL_NONE) begin
                prod_next = PROD_W'(coef_sel * opnd_sel);
            end

            case (uw.acc)
                iirtdf2_pkg::ACC_FIRST: begin
                    acc_next = ACC_W'(sum_reg[0]) + ACC_W'(prod_reg) + ACC_RND;
                end
                iirtdf2_pkg::ACC_UPPER: begin
                    acc_next = ACC_W'(upper_sum) + ACC_W'(prod_reg);
                end
                iirtdf2_pkg::ACC_SUB: begin
                    acc_next = acc_reg - ACC_W'(prod_reg);
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase

            if (uw.wr_y) begin
                if (y_wide > Y_MAX) begin
                    y_next   = Y_MAX_S;
                    sat_next = 1'b1;
                end else if (y_wide < Y_MIN) begin
                    y_next   = Y_MIN_S;
                    sat_next = 1'b1;
                end else begin
                    y_next   = y_wide[SAMPLE_WIDTH-1:0];
                    sat_next = 1'b0;
                end
            end

            if (uw.wr_s) begin
                sum_next[ptr_reg[PW-1:0]] = acc_sat[SW-1:0];
            end

            case (uw.jmp)
                iirtdf2_pkg::JMP_LOOP: begin
                    if (more_pairs) begin
                        ptr_next = ptr_inc;
                        pc_next  = uw.target;
                    end else begin
                        pc_next = pc_reg + iirtdf2_pkg::PC_WIDTH'(1);
                    end
                end
                iirtdf2_pkg::JMP_DONE: begin
                    if (out_free) begin
                        busy_next     = 1'b0;
                        m_tvalid_next = 1'b1;
                        m_data_next   = y_reg;
                        m_tuser_next  = sat_reg;
                        for (int i = 0; i < MAX_ORDER; i++) begin
                            if (i >= int'(n_cur)) begin
                                sum_next[i] = '0;
                            end
                        end
                    end
                end
                default: begin
                    pc_next = pc_reg + iirtdf2_pkg::PC_WIDTH'(1);
                end
            endcase
        end

        // new sample, possibly in the same cycle the previous one finishes
        if (s_tvalid && s_tready) begin
            busy_next = 1'b1;
            pc_next   = iirtdf2_pkg::STEP_B0X;
            ptr_next  = '0;
            x_next    = s_tdata[SAMPLE_WIDTH-1:0];
        end

        if (cfg_valid && cfg_ready) begin
            if (int'(cfg_index) == iirtdf2_pkg::CFG_FILTER_ORDER) begin
                order_next = cfg_data[iirtdf2_pkg::ORDER_WIDTH-1:0];
            end else if (int'(cfg_index) == iirtdf2_pkg::CFG_LEAD_COEF) begin
                b0_next = cfg_data[CW-1:0];
            end else if (int'(cfg_index) >= iirtdf2_pkg::CFG_PAIR_BASE &&
                         int'(cfg_index) < iirtdf2_pkg::CFG_PAIR_BASE + MAX_ORDER) begin
                b_next[cfg_pair] = cfg_data[2*CW-1:CW];
                a_next[cfg_pair] = cfg_data[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pc_reg       <= iirtdf2_pkg::STEP_B0X;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            order_reg    <= iirtdf2_pkg::ORDER_WIDTH'(iirtdf2_pkg::MIN_ORDER);
            b0_reg       <= B0_RESET;
            for (int i = 0; i < MAX_ORDER; i++) begin
                sum_reg[i] <= '0;
                b_reg[i]   <= '0;
                a_reg[i]   <= '0;
            end
        end else begin
            busy_reg     <= busy_next;
            pc_reg       <= pc_next;
            ptr_reg      <= ptr_next;
            m_tvalid_reg <= m_tvalid_next;
            order_reg    <= order_next;
            b0_reg       <= b0_next;
            sum_reg      <= sum_next;
            b_reg        <= b_next;
            a_reg        <= a_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        y_reg       <= y_next;
        sat_reg     <= sat_next;
        m_data_reg  <= m_data_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    always_comb begin
        m_tdata                 = '0;
        m_tdata[SAMPLE_WIDTH-1:0] = m_data_reg;
    end

    `ASSERT_NEVER(a_ptr_in_range, aclk, aresetn, busy_reg && ptr_reg >= n_cur, "pair pointer beyond filter order")
    `ASSERT_AT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready |=> busy_reg && pc_reg == iirtdf2_pkg::STEP_B0X, "accepted sample did not start the program")
    `ASSERT_AT(a_sat_at_limit, aclk, aresetn, m_tvalid_reg && m_tuser_reg |-> m_data_reg == Y_MAX_S || m_data_reg == Y_MIN_S, "saturation flag without clipped value")
    `ASSERT_AT(a_result_from_program, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(finishing), "result appeared without a finished program")

endmodule

// File: dv/tb_iir_transposed_df2_filter_top.sv
module tb_iir_transposed_df2_filter_top;

    localparam int MAX_ORDER      = iirtdf2_pkg::DEF_MAX_ORDER;
    localparam int FRAC_BITS      = iirtdf2_pkg::DEF_COEF_FRAC_BITS;
    localparam int SAMPLE_BITS    = iirtdf2_pkg::DEF_SAMPLE_WIDTH;
    localparam int COEF_WIDTH     = iirtdf2_pkg::COEF_WIDTH;
    localparam int SUM_WIDTH      = iirtdf2_pkg::SUM_WIDTH;
    localparam int CFG_DATA_WIDTH = iirtdf2_pkg::CFG_DATA_WIDTH;
    localparam int MIN_ORDER      = iirtdf2_pkg::MIN_ORDER;
    localparam int INDEX_BITS     = 3;
    // first index past the pair registers, writes there must be dropped
    localparam int SPARE_INDEX  = iirtdf2_pkg::CFG_PAIR_BASE + MAX_ORDER;
    localparam int RESET_CYCLES = 4;
    // idle cycles before a register write, covers the longest sample
    localparam int CFG_SETTLE   = 20;
    localparam int TAIL_CYCLES  = 64;
    localparam int STALL_LIMIT  = 4000;
    localparam int SEGMENTS     = 17;
    localparam int SEG_SAMPLES  = 25;

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint SUM_MAX    = (longint'(1) << (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN    = -SUM_MAX - 1;

    // kinds of planned requests for the driver
    typedef enum logic [1:0] {
        REQ_SAMPLE,
        REQ_WRITE,
        REQ_WAIT_EMPTY,
        REQ_PACE
    } req_kind_t;

    typedef struct {
        req_kind_t              kind;
        logic [INDEX_BITS-1:0]  index;
        logic [CFG_DATA_WIDTH-1:0] data;  // sample in low bits, register data, or pacing percentages
    } plan_entry_t;

    typedef struct {
        logic [SAMPLE_BITS-1:0] y;
        logic                   clipped;
        logic [SAMPLE_BITS-1:0] x;
    } filtered_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // dut ports, all inputs known from time zero
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [SAMPLE_BITS-1:0]      s_tdata   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [SAMPLE_BITS-1:0]      m_tdata;
    logic                        m_tuser;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [INDEX_BITS-1:0]       cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data  = '0;

    iir_transposed_df2_filter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // planned requests and the outputs still owed by the dut
    plan_entry_t request_plan[$];
    filtered_t   filtered_due[$];

    // pacing, changed by REQ_PACE entries
    int send_idle_pct = 0;
    int take_idle_pct = 0;

    // filter image: configuration and transposed-form delay sums
    logic [2:0]          order_reg = 3'd2;
    logic signed [23:0]  lead_coef = 24'sh100000;
    longint              fwd_coef[1:MAX_ORDER] = '{default: 0};
    longint              rev_coef[1:MAX_ORDER] = '{default: 0};
    longint              tap_sum[MAX_ORDER]    = '{default: 0};

    int fail_count    = 0;
    int samples_sent  = 0;
    int writes_done   = 0;
    int outputs_seen  = 0;
    int clipped_seen  = 0;
    int quiet_cycles  = 0;
    int stall_cycles  = 0;

    // ------------------------------------------------------------------
    // filter image
    // ------------------------------------------------------------------

    // register write as the dut should take it, unknown indexes dropped
    task automatic apply_write(input logic [INDEX_BITS-1:0] index,
                               input logic [CFG_DATA_WIDTH-1:0] data);
        int k;
        k = int'(index) - iirtdf2_pkg::CFG_PAIR_BASE + 1;
        if (index == iirtdf2_pkg::CFG_FILTER_ORDER) begin
            order_reg = data[2:0];
        end else if (index == iirtdf2_pkg::CFG_LEAD_COEF) begin
            lead_coef = data[COEF_WIDTH-1:0];
        end else if (k >= 1 && k <= MAX_ORDER) begin
            fwd_coef[k] = longint'($signed(data[2*COEF_WIDTH-1:COEF_WIDTH]));
            rev_coef[k] = longint'($signed(data[COEF_WIDTH-1:0]));
        end
    endtask

    // one sample through the filter image, queues the output it must give
    task automatic filter_step(input logic [SAMPLE_BITS-1:0] x_bits);
        longint    x, acc, y, upper, nxt;
        int        n;
        filtered_t want;
        x = longint'($signed(x_bits));
        // out of range orders clamp into 2..MAX_ORDER
        n = (order_reg < MIN_ORDER) ? MIN_ORDER :
            (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
        acc = tap_sum[0] + longint'(lead_coef) * x + (longint'(1) << (FRAC_BITS - 1));
        y = acc >>> FRAC_BITS;
        want.clipped = 1'b0;
        if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
            want.clipped = 1'b1;
        end else if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
            want.clipped = 1'b1;
        end
        // clipped y feeds back into the sums, each sum saturates to 48 bits
        for (int k = 1; k <= n; k++) begin
            upper = (k < n) ? tap_sum[k] : 0;
            nxt = upper + fwd_coef[k] * x - rev_coef[k] * y;
            if (nxt > SUM_MAX) nxt = SUM_MAX;
            if (nxt < SUM_MIN) nxt = SUM_MIN;
            tap_sum[k-1] = nxt;
        end
        // sums above the order restart from zero
        for (int k = n; k < MAX_ORDER; k++) tap_sum[k] = 0;
        want.y = y[SAMPLE_BITS-1:0];
        want.x = x_bits;
        filtered_due.push_back(want);
    endtask

    // ------------------------------------------------------------------
    // plan building
    // ------------------------------------------------------------------

    function automatic void plan_push(input req_kind_t kind,
                                      input logic [INDEX_BITS-1:0] index,
                                      input logic [CFG_DATA_WIDTH-1:0] data);
        plan_entry_t e;
        e.kind  = kind;
        e.index = index;
        e.data  = data;
        request_plan.push_back(e);
    endfunction

    function automatic void plan_sample(input int value);
        plan_push(REQ_SAMPLE, '0, CFG_DATA_WIDTH'(value[SAMPLE_BITS-1:0]));
    endfunction

    function automatic void plan_write(input int index, input logic [CFG_DATA_WIDTH-1:0] data);
        plan_push(REQ_WRITE, index[INDEX_BITS-1:0], data);
    endfunction

    function automatic void plan_pace(input int send_pct, input int take_pct);
        plan_push(REQ_PACE, '0, CFG_DATA_WIDTH'({send_pct[7:0], take_pct[7:0]}));
    endfunction

    // coefficient within +-span, full scale ends now and then
    function automatic logic [COEF_WIDTH-1:0] rand_coef(input int span);
        int v;
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: begin
                v = int'($urandom_range(2 * span)) - span;
                return v[COEF_WIDTH-1:0];
            end
        endcase
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? int'(SAMPLE_MAX) : int'(SAMPLE_MIN);
            1, 2: return int'($urandom_range(1023)) - 512;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: sample requests and register writes from the plan
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        plan_entry_t head;
        logic        hold_s, hold_cfg, send_now, write_now;
        send_now  = 1'b0;
        write_now = 1'b0;
        if (!aresetn) begin
            s_tvalid     <= 1'b0;
            cfg_valid    <= 1'b0;
            quiet_cycles = 0;
        end else begin
            // retire what was accepted at this edge
            if (s_tvalid && s_tready) begin
                filter_step(s_tdata);
                samples_sent++;
            end
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
                writes_done++;
            end
            hold_s   = s_tvalid && !s_tready;
            hold_cfg = cfg_valid && !cfg_ready;
            // count cycles with nothing in flight before a register write
            if (filtered_due.size() == 0 && !s_tvalid) quiet_cycles++;
            else quiet_cycles = 0;
            if (!hold_s && !hold_cfg && request_plan.size() != 0) begin
                head = request_plan[0];
                case (head.kind)
                    REQ_PACE: begin
                        send_idle_pct = int'(head.data[15:8]);
                        take_idle_pct = int'(head.data[7:0]);
                        void'(request_plan.pop_front());
                    end
                    REQ_WAIT_EMPTY: begin
                        // sender holds off until every output is back
                        if (filtered_due.size() == 0) void'(request_plan.pop_front());
                    end
                    REQ_WRITE: begin
                        if (quiet_cycles >= CFG_SETTLE) begin
                            write_now = 1'b1;
                            void'(request_plan.pop_front());
                        end
                    end
                    default: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            send_now = 1'b1;
                            void'(request_plan.pop_front());
                        end
                    end
                endcase
            end
            // one nonblocking update per signal per edge
            s_tvalid <= hold_s || send_now;
            if (send_now) s_tdata <= head.data[SAMPLE_BITS-1:0];
            cfg_valid <= hold_cfg || write_now;
            if (write_now) begin
                cfg_index <= head.index;
                cfg_data  <= head.data;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random backpressure and output check
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        filtered_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= take_idle_pct);
            if (m_tvalid && m_tready) begin
                outputs_seen++;
                if (m_tuser) clipped_seen++;
                if (filtered_due.size() == 0) begin
                    $error("output request with nothing pending: filtered_sample %0d",
                           $signed(m_tdata));
                    fail_count++;
                end else begin
                    want = filtered_due.pop_front();
                    if (m_tdata !== want.y) begin
                        $error("filtered_sample (x=%0d): expected %0d, actual %0d",
                               $signed(want.x), $signed(want.y), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser !== want.clipped) begin
                        $error("saturated (x=%0d): expected %0b, actual %0b",
                               $signed(want.x), want.clipped, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus plan and end of run
    // ------------------------------------------------------------------
    initial begin
        int                        bspan, aspan;
        logic [2:0]                ord;
        logic [CFG_DATA_WIDTH-1:0] spare;

        // first pacing phase: sender idles 29 of 100, receiver 45
        plan_pace(29, 45);

        // reset configuration is order 2, b0 = 1.0, all pairs zero: y must equal x
        plan_sample(int'(SAMPLE_MAX));
        plan_sample(int'(SAMPLE_MIN));
        plan_sample(0);
        plan_sample(1);
        plan_sample(-1);

        // order 4 with full-scale coefficients, output clips both ways
        plan_write(iirtdf2_pkg::CFG_FILTER_ORDER, 48'd4);
        plan_write(iirtdf2_pkg::CFG_LEAD_COEF, 48'h7FFFFF);
        plan_write(iirtdf2_pkg::CFG_PAIR_BASE,     {24'h800000, 24'h7FFFFF});
        plan_write(iirtdf2_pkg::CFG_PAIR_BASE + 1, {24'h7FFFFF, 24'h800000});
        plan_write(iirtdf2_pkg::CFG_PAIR_BASE + 2, {24'h000000, 24'hFFFFFF});
        plan_write(iirtdf2_pkg::CFG_PAIR_BASE + 3, {24'hFFFFFF, 24'h000001});
        plan_sample(int'(SAMPLE_MAX));
        plan_sample(int'(SAMPLE_MIN));
        plan_sample(0);
        plan_sample(100);
        plan_sample(-100);
        plan_sample(1);

        // order 0 acts as 2, upper sums must restart from zero later
        plan_write(iirtdf2_pkg::CFG_FILTER_ORDER, 48'd0);
        plan_write(iirtdf2_pkg::CFG_LEAD_COEF, 48'h800000);
        plan_sample(int'(SAMPLE_MAX));
        plan_sample(-1);
        plan_sample(0);

        // order 7 acts as MAX_ORDER
        plan_write(iirtdf2_pkg::CFG_FILTER_ORDER, 48'd7);
        plan_write(iirtdf2_pkg::CFG_LEAD_COEF, 48'h0FFFFF);
        plan_sample(int'(SAMPLE_MIN));
        plan_sample(5);
        plan_sample(0);

        // odd order in range, then writes to indexes past the pairs are dropped
        plan_write(iirtdf2_pkg::CFG_FILTER_ORDER, 48'd3);
        plan_sample(1234);
        plan_write(SPARE_INDEX, '1);
        plan_write(SPARE_INDEX + 1, 48'hAAAA_AAAA_AAAA);
        plan_sample(-4321);
        plan_sample(int'(SAMPLE_MAX));

        // random segments: a fresh configuration, then a burst of samples
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 6) plan_pace(45, 29);
            if (seg == 12) plan_pace(0, 0);
            // tame coefficients keep most filters stable, the rest are full scale
            if ($urandom_range(1)) begin
                bspan = 1 << 20;
                aspan = 1 << 18;
            end else begin
                bspan = (1 << 23) - 1;
                aspan = (1 << 23) - 1;
            end
            if ($urandom_range(3) == 0) ord = 3'($urandom_range(7));
            else ord = 3'($urandom_range(MAX_ORDER, MIN_ORDER));
            if ($urandom_range(3) != 0)
                plan_write(iirtdf2_pkg::CFG_FILTER_ORDER, {45'd0, ord});
            if ($urandom_range(3) != 0)
                plan_write(iirtdf2_pkg::CFG_LEAD_COEF, {24'd0, rand_coef(bspan)});
            for (int k = 0; k < MAX_ORDER; k++) begin
                if ($urandom_range(3) != 0)
                    plan_write(iirtdf2_pkg::CFG_PAIR_BASE + k,
                               {rand_coef(bspan), rand_coef(aspan)});
            end
            if ($urandom_range(5) == 0) begin
                spare = CFG_DATA_WIDTH'({$urandom, $urandom});
                plan_write(SPARE_INDEX + $urandom_range(1), spare);
            end
            for (int i = 0; i < SEG_SAMPLES; i++) begin
                // in segments 1, 5, 9 and 13 the sender pauses mid-segment until all outputs are back
                if (seg % 4 == 1 && i == SEG_SAMPLES / 2)
                    plan_push(REQ_WAIT_EMPTY, '0, '0);
                plan_sample(rand_sample());
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for the plan to drain and every output to come back
        while (request_plan.size() != 0 || s_tvalid || cfg_valid || filtered_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (filtered_due.size() != 0) begin
            $error("%0d filtered samples never arrived", filtered_due.size());
            fail_count++;
        end

        $display("covered %0d samples and %0d register writes, %0d of %0d outputs clipped",
                 samples_sent, writes_done, clipped_seen, outputs_seen);
        $display("orders 0..7 incl. clamped ones, dropped spare-index writes, three pacing modes");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/iirtdf2_pkg.sv
rtl/iir_transposed_df2_filter_top.sv
dv/tb_iir_transposed_df2_filter_top.sv
